// File: rtl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/mfmd_pkg.sv
// Shared constants, register codes and control types of the feedback decoder.
`default_nettype none

package mfmd_pkg;

    // parameter defaults
    localparam int WARMUP_FRAMES_DEF    = 50;
    localparam int TURN_BITS_DEF        = 24;
    localparam int STALL_COUNT_BITS_DEF = 16;

    // field widths
    localparam int BYTE_W       = 8;
    localparam int NIBBLE_W     = 4;
    localparam int POS_W        = 16;
    localparam int SPEED_CODE_W = 12;
    localparam int TORQUE_W     = 12;
    localparam int TSIG_W       = 13;
    localparam int POS_OUT_W    = 40;
    localparam int FILT_W       = 17;
    localparam int ALPHA_W      = 17;
    localparam int THR_SPEED_W  = 16;
    localparam int WARM_CNT_W   = 6;
    localparam int STALL_OUT_W  = 16;

    // serial position adder: one hex digit a cycle
    localparam int DIGIT_W    = 4;
    localparam int POS_DIGITS = POS_OUT_W / DIGIT_W;

    // stream and config port widths
    localparam int IN_DATA_W  = 8 * BYTE_W;
    localparam int OUT_DATA_W = 152;
    localparam int OUT_USER_W = 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    // alpha of one: no filtering
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(65536);

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ALPHA        = 2'd0,
        REG_STALL_TORQUE = 2'd1,
        REG_STALL_SPEED  = 2'd2
    } cfg_reg_t;

    // sequencer strobes seen by the serial units
    typedef struct packed {
        logic load;  // new frame, load shift registers
        logic run;   // one serial step
        logic fin;   // write back filter result
    } mfmd_ctl_t;

endpackage

`default_nettype wire

// File: rtl/motor_feedback_multiturn_decoder.sv
// Top level: frame unpacking, turn counting, stall counting and sequencing.
//
//  port group   dir  handshake            contents
//  s_*          in   s_tvalid / s_tready  one 8-byte feedback frame per word
//  m_*          out  m_tvalid / m_tready  one decoded result per word
//  cfg_*        in   cfg_valid / cfg_ready register index and write data
//
// A frame goes from acceptance through S_RUN, the 17 one-bit steps of the alpha
// multiply in the speed filter, then S_FILT, S_POST and S_EMIT before the next;
// the 40-bit position adder runs one hex digit a cycle and finishes in S_RUN.
// Reset is synchronous and active low; all state is registers, no clearing pass.
// A finished result waits in the output register; the next frame is taken
// while it waits, and its own result holds until the previous word is taken.
// Config writes are always ready.
`default_nettype none
`include "assert_macros.svh"

module motor_feedback_multiturn_decoder #(
    parameter int WARMUP_FRAMES    = mfmd_pkg::WARMUP_FRAMES_DEF,
    parameter int TURN_BITS        = mfmd_pkg::TURN_BITS_DEF,
    parameter int STALL_COUNT_BITS = mfmd_pkg::STALL_COUNT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // frame input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // bytes 0..7 from bit 0 up: byte_id_error, byte_pos_high, byte_pos_low,
    // byte_vel_high, byte_vel_torque, byte_torque_low, byte_temp_mos,
    // byte_temp_rotor
    input  logic [mfmd_pkg::IN_DATA_W-1:0]     s_tdata,
    // result output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // from bit 0 up: motor_id(4), error_code(4), total_position(40),
    // absolute_position(40), filtered_speed_out(17), torque_signed(13),
    // rotor_temperature(8), mos_temperature(8), stall_frames(16), 2 zero bits
    output logic [mfmd_pkg::OUT_DATA_W-1:0]    m_tdata,
    // bit 0: warming_up
    output logic [mfmd_pkg::OUT_USER_W-1:0]    m_tuser,
    // configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mfmd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mfmd_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PW     = mfmd_pkg::POS_W;
    localparam int BW     = mfmd_pkg::BYTE_W;
    localparam int FW     = mfmd_pkg::FILT_W;
    localparam int TW     = mfmd_pkg::TORQUE_W;
    localparam int SW     = mfmd_pkg::TSIG_W;
    localparam int STEP_W = $clog2(mfmd_pkg::ALPHA_W);
    localparam int WCW    = mfmd_pkg::WARM_CNT_W;

    localparam logic signed [PW:0]       HALF_SPAN = (PW+1)'(32768);
    localparam logic [SW-1:0]            TSIG_MID  = SW'(4095);
    localparam logic [STALL_COUNT_BITS-1:0] STALL_MAX = '1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_FILT,
        S_POST,
        S_EMIT
    } state_t;

    state_t                          state_reg;
    logic [STEP_W-1:0]               step_reg;
    logic                            m_tvalid_reg;
    logic [mfmd_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic [mfmd_pkg::OUT_USER_W-1:0] m_tuser_reg;

    // config registers
    logic [mfmd_pkg::ALPHA_W-1:0]     alpha_reg;
    logic [TW-1:0]                    thr_torque_reg;
    logic [mfmd_pkg::THR_SPEED_W-1:0] thr_speed_reg;

    // decoder state
    logic [PW-1:0]               prev_pos_reg;
    logic [TURN_BITS-1:0]        turns_reg;
    logic [PW-1:0]               offset_reg;
    logic [WCW-1:0]              warm_cnt_reg;
    logic                        captured_reg;
    logic [STALL_COUNT_BITS-1:0] stall_count_reg;

    // latched frame
    logic [BW-1:0] id_err_reg;
    logic [TW-1:0] torque_reg;
    logic [BW-1:0] tmos_reg;
    logic [BW-1:0] trot_reg;
    logic          warm_reg;

    logic                       accept;
    logic                       emit;
    mfmd_pkg::mfmd_ctl_t        ctl;
    logic [PW-1:0]              pos_in;
    logic [mfmd_pkg::SPEED_CODE_W-1:0] vel_in;
    logic [TW-1:0]              torq_in;
    logic                       warm_now;
    logic signed [PW:0]         delta;
    logic [TURN_BITS-1:0]       turns_next;
    logic [PW-1:0]              offset_next;
    logic [mfmd_pkg::POS_OUT_W-1:0] abs_pos;
    logic [mfmd_pkg::POS_OUT_W-1:0] tot_pos;
    logic signed [FW-1:0]       filt;
    logic [SW-1:0]              tsig;
    logic [TW-1:0]              tsig_mag;
    logic [FW-1:0]              filt_mag;
    logic                       stall_hit;

    // frame fields
    assign pos_in  = {s_tdata[2*BW-1:BW], s_tdata[3*BW-1:2*BW]};
    assign vel_in  = {s_tdata[4*BW-1:3*BW], s_tdata[5*BW-1:5*BW-4]};
    assign torq_in = {s_tdata[4*BW+3:4*BW], s_tdata[6*BW-1:5*BW]};

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // result register free for a new word
    assign emit = (state_reg == S_EMIT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        ctl.load = accept;
        ctl.run  = (state_reg == S_RUN);
        ctl.fin  = (state_reg == S_FILT);
    end

    // warm-up test and turn unwrapping
    assign warm_now = (warm_cnt_reg < WCW'(WARMUP_FRAMES)) && !captured_reg;
    assign delta    = $signed({1'b0, pos_in}) - $signed({1'b0, prev_pos_reg});

    always_comb begin
        turns_next = turns_reg;
        if (!warm_now) begin
            if (delta >= HALF_SPAN) begin
                turns_next = turns_reg - TURN_BITS'(1);
            end else if (delta <= -HALF_SPAN) begin
                turns_next = turns_reg + TURN_BITS'(1);
            end
        end
    end

    assign offset_next = warm_now ? pos_in : offset_reg;

    // serial units
    mfmd_pos_serial #(
        .TURN_BITS (TURN_BITS)
    ) u_pos (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctl               (ctl),
        .turns             (turns_next),
        .position          (pos_in),
        .zero_offset       (offset_next),
        .absolute_position (abs_pos),
        .total_position    (tot_pos)
    );

    mfmd_speed_filter u_speed (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctl        (ctl),
        .speed_code (vel_in),
        .alpha      (alpha_reg),
        .filt_speed (filt)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_reg      <= mfmd_pkg::ALPHA_ONE;
            thr_torque_reg <= '1;
            thr_speed_reg  <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (mfmd_pkg::cfg_reg_t'(cfg_index))
                mfmd_pkg::REG_ALPHA:        alpha_reg      <= cfg_data;
                mfmd_pkg::REG_STALL_TORQUE: thr_torque_reg <= cfg_data[TW-1:0];
                mfmd_pkg::REG_STALL_SPEED:
                    thr_speed_reg <= cfg_data[mfmd_pkg::THR_SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // per-frame state updated at acceptance
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_pos_reg <= '0;
            turns_reg    <= '0;
            offset_reg   <= '0;
            warm_cnt_reg <= '0;
            captured_reg <= 1'b0;
        end else if (accept) begin
            prev_pos_reg <= pos_in;
            turns_reg    <= turns_next;
            offset_reg   <= offset_next;
            if (warm_now) begin
                warm_cnt_reg <= warm_cnt_reg + WCW'(1);
            end else begin
                captured_reg <= 1'b1;
            end
        end
    end

    // frame payload kept for the result
    always_ff @(posedge aclk) begin
        if (accept) begin
            id_err_reg <= s_tdata[BW-1:0];
            torque_reg <= torq_in;
            tmos_reg   <= s_tdata[7*BW-1:6*BW];
            trot_reg   <= s_tdata[8*BW-1:7*BW];
            warm_reg   <= warm_now;
        end
    end

    // stall test on the new filtered speed
    assign tsig      = {torque_reg, 1'b0} - TSIG_MID;
    assign tsig_mag  = TW'(tsig[SW-1] ? (~tsig + SW'(1)) : tsig);
    assign filt_mag  = filt[FW-1] ? FW'(-filt) : FW'(filt);
    assign stall_hit = (tsig_mag > thr_torque_reg) && (filt_mag < FW'(thr_speed_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stall_count_reg <= '0;
        end else if (state_reg == S_POST && !warm_reg) begin
            if (!stall_hit) begin
                stall_count_reg <= '0;
            end else if (stall_count_reg != STALL_MAX) begin
                stall_count_reg <= stall_count_reg + STALL_COUNT_BITS'(1);
            end
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        state_reg <= S_RUN;
                        step_reg  <= '0;
                    end
                end
                S_RUN: begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(mfmd_pkg::ALPHA_W - 1)) begin
                        state_reg <= S_FILT;
                    end
                end
                S_FILT: state_reg <= S_POST;
                S_POST: state_reg <= S_EMIT;
                S_EMIT: begin
                    if (emit) begin
                        m_tuser_reg  <= warm_reg;
                        m_tdata_reg  <= {2'b00,
                                         mfmd_pkg::STALL_OUT_W'(stall_count_reg),
                                         tmos_reg, trot_reg, tsig, filt,
                                         abs_pos, tot_pos,
                                         id_err_reg[BW-1:4], id_err_reg[3:0]};
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `ASSERT_NXT(a_one_frame_in_flight, aclk, aresetn, accept, !s_tready)
    `ASSERT_NXT(a_turns_only_on_accept, aclk, aresetn, !accept, $stable(turns_reg))
    `ASSERT_NXT(a_no_stall_in_warmup, aclk, aresetn, (state_reg == S_POST) && warm_reg,
                $stable(stall_count_reg))
    `ASSERT_IMP(a_result_from_emit, aclk, aresetn, $rose(m_tvalid_reg),
                $past(state_reg == S_EMIT))

endmodule

`default_nettype wire

// File: rtl/mfmd_pos_serial.sv
// Digit-serial 40-bit adder forming absolute and offset-corrected position.
`default_nettype none

module mfmd_pos_serial #(
    parameter int TURN_BITS = mfmd_pkg::TURN_BITS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  mfmd_pkg::mfmd_ctl_t                    ctl,
    input  logic [TURN_BITS-1:0]                   turns,
    input  logic [mfmd_pkg::POS_W-1:0]             position,
    input  logic [mfmd_pkg::POS_W-1:0]             zero_offset,
    output logic [mfmd_pkg::POS_OUT_W-1:0]         absolute_position,
    output logic [mfmd_pkg::POS_OUT_W-1:0]         total_position
);

    localparam int W     = mfmd_pkg::POS_OUT_W;
    localparam int DW    = mfmd_pkg::DIGIT_W;
    localparam int CNT_W = $clog2(mfmd_pkg::POS_DIGITS + 1);

    logic [W-1:0]     a_sr_reg, b_sr_reg, c_sr_reg, z_sr_reg;
    logic [W-1:0]     abs_sr_reg, tot_sr_reg;
    logic [1:0]       cy3_reg;
    logic             cy2_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [W-1:0]     turns_ext;
    logic [DW+1:0]    sum3;
    logic [DW:0]      sum2;
    logic             stepping;

    // turns*65535 = turns*65536 + ~turns + 1
    assign turns_ext = {{(W-TURN_BITS){turns[TURN_BITS-1]}}, turns};
    assign stepping  = ctl.run && (cnt_reg != CNT_W'(mfmd_pkg::POS_DIGITS));

    // three-operand digit add, then subtract the offset digit
    assign sum3 = (DW+2)'(a_sr_reg[DW-1:0]) + (DW+2)'(b_sr_reg[DW-1:0])
                + (DW+2)'(c_sr_reg[DW-1:0]) + (DW+2)'(cy3_reg);
    assign sum2 = (DW+1)'(sum3[DW-1:0]) + (DW+1)'(z_sr_reg[DW-1:0]) + (DW+1)'(cy2_reg);

    // digit counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= CNT_W'(mfmd_pkg::POS_DIGITS);
        end else if (ctl.load) begin
            cnt_reg <= '0;
        end else if (stepping) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // operand and result shift registers, low digit first
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            a_sr_reg <= turns_ext << mfmd_pkg::POS_W;
            b_sr_reg <= ~turns_ext;
            c_sr_reg <= W'(position);
            z_sr_reg <= ~W'(zero_offset);
            cy3_reg  <= 2'd1;
            cy2_reg  <= 1'b1;
        end else if (stepping) begin
            a_sr_reg   <= a_sr_reg >> DW;
            b_sr_reg   <= b_sr_reg >> DW;
            c_sr_reg   <= c_sr_reg >> DW;
            z_sr_reg   <= z_sr_reg >> DW;
            cy3_reg    <= sum3[DW+1:DW];
            cy2_reg    <= sum2[DW];
            abs_sr_reg <= {sum3[DW-1:0], abs_sr_reg[W-1:DW]};
            tot_sr_reg <= {sum2[DW-1:0], tot_sr_reg[W-1:DW]};
        end
    end

    assign absolute_position = abs_sr_reg;
    assign total_position    = tot_sr_reg;

endmodule

`default_nettype wire

// File: rtl/mfmd_speed_filter.sv
// Speed normalisation and bit-serial first-order low-pass filter.
`default_nettype none

module mfmd_speed_filter (
    input  logic                                       aclk,
    input  logic                                       aresetn,
    input  mfmd_pkg::mfmd_ctl_t                        ctl,
    input  logic [mfmd_pkg::SPEED_CODE_W-1:0]          speed_code,
    input  logic [mfmd_pkg::ALPHA_W-1:0]               alpha,
    output logic signed [mfmd_pkg::FILT_W-1:0]         filt_speed
);

    localparam int FW    = mfmd_pkg::FILT_W;
    localparam int AW    = mfmd_pkg::ALPHA_W;
    localparam int VW    = mfmd_pkg::SPEED_CODE_W;
    localparam int NW    = VW + 1;
    localparam int YW    = VW + 4;
    localparam int DIFFW = FW + 1;
    localparam int ACC_W = AW + DIFFW;
    localparam int RND_W = ACC_W - 16;
    localparam int QW    = RND_W + 1;

    localparam logic [NW-1:0]        CODE_MID = NW'(4095);
    localparam logic [YW-1:0]        HALF_DIV = YW'(2047);
    localparam logic [NW-1:0]        DIVISOR  = NW'(4095);
    localparam logic signed [QW-1:0] Q_MAX    = QW'(32768);
    localparam logic signed [QW-1:0] Q_MIN    = -QW'(32768);
    localparam logic [AW-1:0]        ALPHA_ONE_C = mfmd_pkg::ALPHA_ONE;

    logic signed [FW-1:0]    filt_reg;
    logic signed [DIFFW-1:0] d_reg;
    logic [AW-1:0]           a_sr_reg;
    logic signed [ACC_W-1:0] acc_reg;

    logic [NW-1:0]           n_code;
    logic                    n_neg;
    logic [VW-1:0]           n_mag;
    logic [YW-1:0]           y_val;
    logic [3:0]              q0;
    logic [NW-1:0]           rem;
    logic [3:0]              q_fix;
    logic [FW-1:0]           mag;
    logic signed [FW-1:0]    raw;
    logic [AW-1:0]           a_sat;
    logic signed [ACC_W-1:0] rnd_sum;
    logic signed [QW-1:0]    q_sum;
    logic signed [FW-1:0]    q_clamped;

    // raw = round((2v - 4095) * 32768 / 4095); 32768m/4095 = 8m + 8m/4095
    assign n_code = {speed_code, 1'b0} - CODE_MID;
    assign n_neg  = n_code[NW-1];
    assign n_mag  = VW'(n_neg ? (~n_code + NW'(1)) : n_code);
    assign y_val  = {1'b0, n_mag, 3'b000} + HALF_DIV;
    assign q0     = y_val[YW-1:YW-4];
    assign rem    = {1'b0, y_val[VW-1:0]} + NW'(q0);
    assign q_fix  = q0 + ((rem >= DIVISOR) ? 4'd1 : 4'd0);
    assign mag    = {2'b00, n_mag, 3'b000} + FW'(q_fix);
    assign raw    = n_neg ? -$signed(mag) : $signed(mag);

    // weight saturates at one
    assign a_sat = (alpha > ALPHA_ONE_C) ? ALPHA_ONE_C : alpha;

    // new = last + round(alpha * (raw - last) / 65536), clamped
    assign rnd_sum   = acc_reg + ACC_W'(32768);
    assign q_sum     = {filt_reg[FW-1], filt_reg[FW-1], filt_reg[FW-1], filt_reg}
                     + {rnd_sum[ACC_W-1], rnd_sum[ACC_W-1:16]};
    assign q_clamped = (q_sum > Q_MAX) ? FW'(Q_MAX)
                     : (q_sum < Q_MIN) ? FW'(Q_MIN) : q_sum[FW-1:0];

    // filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg <= '0;
        end else if (ctl.fin) begin
            filt_reg <= q_clamped;
        end
    end

    // shift-add multiply, alpha MSB first
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            d_reg    <= {raw[FW-1], raw} - {filt_reg[FW-1], filt_reg};
            a_sr_reg <= a_sat;
            acc_reg  <= '0;
        end else if (ctl.run) begin
            acc_reg  <= (acc_reg <<< 1)
                      + (a_sr_reg[AW-1] ? {{(ACC_W-DIFFW){d_reg[DIFFW-1]}}, d_reg}
                                        : ACC_W'(0));
            a_sr_reg <= a_sr_reg << 1;
        end
    end

    assign filt_speed = filt_reg;

endmodule

`default_nettype wire

// File: tb/sv/motor_feedback_multiturn_decoder_tb.sv
// Self-checking testbench for the multiturn feedback decoder: stream frames in, check results.
`timescale 1ns / 1ps

module motor_feedback_multiturn_decoder_tb;

    localparam int QUIET_LIMIT = 3000;   // cycles without any handshake
    localparam int SETTLE_CYCLES = 30;    // > one frame time of the block
    localparam int PHASE_FRAMES = 40;
    localparam int NUM_PHASES = 9;
    localparam logic [mfmd_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register behind it

    // one feedback frame, byte 0 in the lowest bits
    typedef struct packed {
        logic [7:0] temp_rotor;
        logic [7:0] temp_mos;
        logic [7:0] torque_low;
        logic [7:0] vel_torque;
        logic [7:0] vel_high;
        logic [7:0] pos_low;
        logic [7:0] pos_high;
        logic [7:0] id_error;
    } frame_t;

    // decoded result word, motor id in the lowest bits
    typedef struct packed {
        logic [1:0]  pad;
        logic [15:0] stall_frames;
        logic [7:0]  mos_temp;
        logic [7:0]  rotor_temp;
        logic [12:0] torque_signed;
        logic [16:0] filt_speed;
        logic [39:0] absolute_pos;
        logic [39:0] total_pos;
        logic [3:0]  error_code;
        logic [3:0]  motor_id;
    } decoded_t;

    typedef struct {
        decoded_t word;
        logic     warming;
    } expected_t;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [mfmd_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [mfmd_pkg::OUT_DATA_W-1:0] m_tdata;
    logic [mfmd_pkg::OUT_USER_W-1:0] m_tuser;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [mfmd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mfmd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    motor_feedback_multiturn_decoder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // stimulus and expectation stores
    frame_t    frame_q[$];
    expected_t decoded_q[$];
    int        mismatch_count = 0;
    int        quiet_cycles = 0;

    // decoder state as predicted
    logic [16:0] alpha_weight = 17'd65536;
    logic [11:0] torque_limit = 12'd4095;
    logic [15:0] speed_limit = 16'd0;
    logic [15:0] last_pos = '0;
    logic [23:0] turn_ctr = '0;
    logic [15:0] zero_pos = '0;
    int          speed_state = 0;
    logic [5:0]  warmup_seen = '0;
    logic        offset_locked = 1'b0;
    logic [15:0] stall_run = '0;

    // stimulus walk state
    logic [15:0] walk_pos = '0;

    // driver / receiver pacing
    int burst_left = 0;
    int gap_left = 0;
    int ready_pct = 100;
    int pattern_left = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(string msg);
        $display("mismatch @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    // speed code to Q1.15, rounded to nearest
    function automatic int speed_q15(logic [11:0] code);
        longint n, mag;
        n = (2 * longint'(code) - 4095) * 32768;
        mag = (n < 0) ? -n : n;
        mag = (mag + 2047) / 4095;
        return (n < 0) ? -int'(mag) : int'(mag);
    endfunction

    // first-order low-pass, alpha saturated at one, result clamped
    function automatic int lowpass(int prev, int sample);
        longint a, sum, q;
        a = (alpha_weight > 17'd65536) ? 65536 : longint'(alpha_weight);
        sum = (65536 - a) * longint'(prev) + a * longint'(sample);
        q = (sum + 32768) >>> 16;
        if (q > 32768) q = 32768;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    // advance the predicted state by one frame and build its result
    function automatic expected_t decode_frame(frame_t f);
        logic [15:0] pos;
        logic [11:0] vel, torq;
        int          tsig, tmag, smag, delta;
        longint      turns, abs_pos;
        expected_t   e;
        pos  = {f.pos_high, f.pos_low};
        vel  = {f.vel_high, f.vel_torque[7:4]};
        torq = {f.vel_torque[3:0], f.torque_low};
        tsig = 2 * int'(torq) - 4095;
        e.warming = (int'(warmup_seen) < mfmd_pkg::WARMUP_FRAMES_DEF) && !offset_locked;
        if (e.warming) begin
            last_pos = pos;
            zero_pos = pos;
            speed_state = lowpass(speed_state, speed_q15(vel));
            warmup_seen = warmup_seen + 6'd1;
        end else begin
            delta = int'(pos) - int'(last_pos);
            offset_locked = 1'b1;
            if (delta >= 32768) turn_ctr = turn_ctr - 24'd1;
            else if (delta <= -32768) turn_ctr = turn_ctr + 24'd1;
            last_pos = pos;
            speed_state = lowpass(speed_state, speed_q15(vel));
            smag = (speed_state < 0) ? -speed_state : speed_state;
            tmag = (tsig < 0) ? -tsig : tsig;
            if (tmag > int'(torque_limit) && smag < int'(speed_limit)) begin
                if (stall_run != 16'hFFFF) stall_run = stall_run + 16'd1;
            end else begin
                stall_run = '0;
            end
        end
        turns   = longint'($signed(turn_ctr));
        abs_pos = turns * 65535 + longint'(pos);
        e.word.pad           = '0;
        e.word.stall_frames  = stall_run;
        e.word.mos_temp      = f.temp_mos;
        e.word.rotor_temp    = f.temp_rotor;
        e.word.torque_signed = 13'(tsig);
        e.word.filt_speed    = 17'(speed_state);
        e.word.absolute_pos  = 40'(abs_pos);
        e.word.total_pos     = 40'(abs_pos - longint'(zero_pos));
        e.word.error_code    = f.id_error[7:4];
        e.word.motor_id      = f.id_error[3:0];
        return e;
    endfunction

    function automatic frame_t make_frame(logic [7:0] id_err, logic [15:0] pos,
                                          logic [11:0] vel, logic [11:0] torq,
                                          logic [7:0] mos, logic [7:0] rot);
        frame_t f;
        f.id_error   = id_err;
        f.pos_high   = pos[15:8];
        f.pos_low    = pos[7:0];
        f.vel_high   = vel[11:4];
        f.vel_torque = {vel[3:0], torq[11:8]};
        f.torque_low = torq[7:0];
        f.temp_mos   = mos;
        f.temp_rotor = rot;
        return f;
    endfunction

    // mostly a plausible shaft walk, now and then a wild frame
    function automatic frame_t next_walk_frame();
        int          step, dir;
        logic [11:0] vel;
        if ($urandom_range(0, 6) == 0)
            return frame_t'({$urandom, $urandom});
        dir = $urandom_range(0, 1) ? 1 : -1;
        case ($urandom_range(0, 9))
            0: step = dir * (30000 + int'($urandom_range(0, 5535)));
            1: step = dir * ($urandom_range(0, 1) ? 32768 : 32767);
            default: step = int'($urandom_range(0, 4000)) - 2000;
        endcase
        walk_pos = walk_pos + 16'(step);
        if ($urandom_range(0, 1))
            vel = 12'(2007 + int'($urandom_range(0, 80)));
        else
            vel = 12'($urandom_range(0, 4095));
        return make_frame(8'($urandom), walk_pos, vel, 12'($urandom_range(0, 4095)),
                          8'($urandom), 8'($urandom));
    endfunction

    task automatic queue_walk(int count);
        repeat (count) frame_q.push_back(next_walk_frame());
    endtask

    task automatic write_reg(logic [mfmd_pkg::CFG_IDX_W-1:0] idx,
                             logic [mfmd_pkg::CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // block drained: nothing queued, nothing in flight, then settle
    task automatic wait_idle();
        while (frame_q.size() != 0 || s_tvalid || decoded_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // frame driver: bursts with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (frame_q.size() != 0) begin
                s_tdata  <= frame_q.pop_front();
                s_tvalid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver: ready density changes from stretch to stretch
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left = $urandom_range(20, 300);
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 70;
                    2: ready_pct = 35;
                    default: ready_pct = 8;
                endcase
            end
            pattern_left--;
            m_tready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // monitor: register writes, accepted frames, accepted results
    always @(posedge aclk) begin
        expected_t e;
        decoded_t  got;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mfmd_pkg::REG_ALPHA:        alpha_weight = cfg_data;
                    mfmd_pkg::REG_STALL_TORQUE: torque_limit = cfg_data[11:0];
                    mfmd_pkg::REG_STALL_SPEED:  speed_limit = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = decoded_t'(m_tdata);
                if (decoded_q.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing expected: %h", m_tdata));
                end else begin
                    e = decoded_q.pop_front();
                    check_field("motor_id", got.motor_id, e.word.motor_id);
                    check_field("error_code", got.error_code, e.word.error_code);
                    check_field("total_position", got.total_pos, e.word.total_pos);
                    check_field("absolute_position", got.absolute_pos, e.word.absolute_pos);
                    check_field("filtered_speed", got.filt_speed, e.word.filt_speed);
                    check_field("torque_signed", got.torque_signed, e.word.torque_signed);
                    check_field("rotor_temperature", got.rotor_temp, e.word.rotor_temp);
                    check_field("mos_temperature", got.mos_temp, e.word.mos_temp);
                    check_field("stall_frames", got.stall_frames, e.word.stall_frames);
                    check_field("pad", got.pad, e.word.pad);
                    check_field("warming_up", m_tuser[0], e.warming);
                end
            end
            if (s_tvalid && s_tready)
                decoded_q.push_back(decode_frame(frame_t'(s_tdata)));
        end
    end

    // watchdog on handshake activity
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [mfmd_pkg::CFG_DATA_W-1:0] alpha_cfg, torque_cfg, speed_cfg;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // write to an index with no register: must leave defaults alone
        write_reg(REG_SPARE, '1);

        // warm-up: corner frames, then a walk up to the warm-up length
        frame_q.push_back(make_frame(8'h00, 16'h0000, 12'h000, 12'h000, 8'h00, 8'h00));
        frame_q.push_back(make_frame(8'hFF, 16'hFFFF, 12'hFFF, 12'hFFF, 8'hFF, 8'hFF));
        frame_q.push_back(make_frame(8'hA5, 16'h8000, 12'h7FF, 12'h800, 8'h80, 8'h80));
        frame_q.push_back(make_frame(8'h5A, 16'h7FFF, 12'h800, 12'h7FF, 8'h7F, 8'h7F));
        frame_q.push_back(make_frame(8'h3C, 16'h5555, 12'h555, 12'hAAA, 8'h55, 8'hAA));
        frame_q.push_back(make_frame(8'hC3, 16'hAAAA, 12'hAAA, 12'h555, 8'hAA, 8'h55));
        frame_q.push_back(make_frame(8'h0F, 16'h1234, 12'h001, 12'hFFE, 8'h01, 8'hFE));
        frame_q.push_back(make_frame(8'hF0, 16'h1234, 12'hFFE, 12'h001, 8'hFE, 8'h01));
        walk_pos = 16'h1234;
        queue_walk(mfmd_pkg::WARMUP_FRAMES_DEF - 8);

        // after warm-up: wrap in both directions, exactly half span and just under
        frame_q.push_back(make_frame(8'h01, 16'h0000, 12'h000, 12'h000, 8'h00, 8'h80));
        frame_q.push_back(make_frame(8'h12, 16'hFFFF, 12'hFFF, 12'hFFF, 8'hFF, 8'h7F));
        frame_q.push_back(make_frame(8'h23, 16'h0000, 12'h800, 12'h000, 8'h10, 8'hF0));
        frame_q.push_back(make_frame(8'h34, 16'h8000, 12'h7FF, 12'hFFF, 8'h20, 8'h0F));
        frame_q.push_back(make_frame(8'h45, 16'h0000, 12'h000, 12'h800, 8'h30, 8'hE0));
        frame_q.push_back(make_frame(8'h56, 16'h7FFF, 12'hFFF, 12'h7FF, 8'h40, 8'h1F));
        frame_q.push_back(make_frame(8'h67, 16'h0000, 12'h123, 12'hEDC, 8'h50, 8'hD0));
        frame_q.push_back(make_frame(8'h78, 16'hFFFF, 12'hEDC, 12'h123, 8'h60, 8'h2F));
        frame_q.push_back(make_frame(8'h89, 16'h7FFF, 12'h800, 12'h000, 8'h70, 8'hC0));
        frame_q.push_back(make_frame(8'h9A, 16'hFFFF, 12'h7FF, 12'hFFF, 8'h80, 8'h3F));
        walk_pos = 16'hFFFF;
        wait_idle();

        // register settings, extremes first, then random ones
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0: begin  // filter frozen, every frame stall-like
                    alpha_cfg = '0; torque_cfg = '0; speed_cfg = '1;
                end
                1: begin  // alpha above one, torque never large enough
                    alpha_cfg = '1; torque_cfg = '1; speed_cfg = 17'd32768;
                end
                2: begin  // very slow filter
                    alpha_cfg = 17'd1; torque_cfg = '0; speed_cfg = 17'd32768;
                end
                3: begin
                    alpha_cfg = 17'd65536; torque_cfg = 17'd2000; speed_cfg = 17'd1000;
                end
                default: begin
                    case ($urandom_range(0, 3))
                        0: alpha_cfg = 17'($urandom_range(0, 1023));
                        1: alpha_cfg = 17'($urandom_range(60000, 65536));
                        2: alpha_cfg = 17'($urandom_range(65536, 131071));
                        default: alpha_cfg = 17'($urandom);
                    endcase
                    torque_cfg = 17'($urandom);
                    speed_cfg = $urandom_range(0, 1) ? 17'($urandom_range(0, 40000))
                                                     : 17'($urandom);
                end
            endcase
            write_reg(mfmd_pkg::REG_ALPHA, alpha_cfg);
            write_reg(mfmd_pkg::REG_STALL_TORQUE, torque_cfg);
            write_reg(mfmd_pkg::REG_STALL_SPEED, speed_cfg);
            queue_walk(PHASE_FRAMES);
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
